FILE: design/qrpi_pkg.sv
//------------------------------------------------------------------------------
// qrpi_pkg
// shared widths, register indexes, reset gains, saturation and multiply helpers
//------------------------------------------------------------------------------
`default_nettype none

package qrpi_pkg;

   localparam int RATE_W   = 16;
   localparam int THRUST_W = 16;
   localparam int GAIN_W   = 24;
   localparam int MODE_W   = 2;
   localparam int OUT_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int AXES     = 3;

   // rate error, product, integral sum, rounded sum, pi output, mix sum
   localparam int ERR_W    = RATE_W + 1;
   localparam int PROD_W   = ERR_W + GAIN_W + 1;
   localparam int ACCS_W   = PROD_W + 1;
   localparam int PSUM_W   = PROD_W + 1;
   localparam int PID_W    = PSUM_W - FRAC_W;
   localparam int MIX_W    = PID_W + 2;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_ROLL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_YAW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_ROLL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_PITCH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_YAW   = 3'd6;

   localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GYRO = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MS   = 2'd2;

   localparam logic SRC_GYRO = 1'b0;
   localparam logic SRC_MS   = 1'b1;

   localparam logic [GAIN_W-1:0] KP_ROLL_RST  = 24'd1376256;
   localparam logic [GAIN_W-1:0] KP_PITCH_RST = 24'd1179648;
   localparam logic [GAIN_W-1:0] KP_YAW_RST   = 24'd2621440;
   localparam logic [GAIN_W-1:0] KI_ROLL_RST  = 24'd1114;
   localparam logic [GAIN_W-1:0] KI_PITCH_RST = 24'd983;
   localparam logic [GAIN_W-1:0] KI_YAW_RST   = 24'd983;

   localparam logic signed [PSUM_W-1:0] ROUND_HALF = PSUM_W'(1) <<< (FRAC_W - 1);

   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [OUT_W-1:0]  word_type;
   typedef logic signed [PID_W-1:0]  pid_type;
   typedef logic [GAIN_W-1:0]        gain_type;

   // clamp the integral sum to signed 32 bits
   function automatic word_type sat_acc(input logic signed [ACCS_W-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[ACCS_W-1:OUT_W-1];
      all_zero = ~|v[ACCS_W-1:OUT_W-1];
      if (all_one || all_zero) begin
         sat_acc = v[OUT_W-1:0];
      end else if (v[ACCS_W-1]) begin
         sat_acc = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_acc = {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // signed gain product, gain taken as unsigned
   function automatic prod_type gain_mul(input err_type e, input gain_type g);
      logic signed [GAIN_W:0] gs;
      gs = $signed({1'b0, g});
      gain_mul = PROD_W'(e * gs);
   endfunction

endpackage

`default_nettype wire

FILE: design/qrpi_req_if.sv
//------------------------------------------------------------------------------
// qrpi_req_if
// input channel: one tick with measured and target rates and thrust
//------------------------------------------------------------------------------
`default_nettype none

interface qrpi_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     tick_source;
   logic signed [qrpi_pkg::RATE_W-1:0]       meas_roll;
   logic signed [qrpi_pkg::RATE_W-1:0]       meas_pitch;
   logic signed [qrpi_pkg::RATE_W-1:0]       meas_yaw;
   logic signed [qrpi_pkg::RATE_W-1:0]       tgt_roll;
   logic signed [qrpi_pkg::RATE_W-1:0]       tgt_pitch;
   logic signed [qrpi_pkg::RATE_W-1:0]       tgt_yaw;
   logic [qrpi_pkg::THRUST_W-1:0]            thrust;

   modport source (
      output valid, tick_source, meas_roll, meas_pitch, meas_yaw,
             tgt_roll, tgt_pitch, tgt_yaw, thrust,
      input  ready
   );

   modport sink (
      input  valid, tick_source, meas_roll, meas_pitch, meas_yaw,
             tgt_roll, tgt_pitch, tgt_yaw, thrust,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/qrpi_rsp_if.sv
//------------------------------------------------------------------------------
// qrpi_rsp_if
// result channel: four motor commands and three pi outputs
//------------------------------------------------------------------------------
`default_nettype none

interface qrpi_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qrpi_pkg::OUT_W-1:0]  motor_front_left;
   logic signed [qrpi_pkg::OUT_W-1:0]  motor_front_right;
   logic signed [qrpi_pkg::OUT_W-1:0]  motor_back_right;
   logic signed [qrpi_pkg::OUT_W-1:0]  motor_back_left;
   logic signed [qrpi_pkg::OUT_W-1:0]  pid_roll;
   logic signed [qrpi_pkg::OUT_W-1:0]  pid_pitch;
   logic signed [qrpi_pkg::OUT_W-1:0]  pid_yaw;

   modport source (
      output valid, motor_front_left, motor_front_right, motor_back_right,
             motor_back_left, pid_roll, pid_pitch, pid_yaw,
      input  ready
   );

   modport sink (
      input  valid, motor_front_left, motor_front_right, motor_back_right,
             motor_back_left, pid_roll, pid_pitch, pid_yaw,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/quad_rate_pi_motor_mixer_unit.sv
//------------------------------------------------------------------------------
// quad_rate_pi_motor_mixer_unit
// rate pi controller for roll, pitch and yaw with x-frame motor mixer
//------------------------------------------------------------------------------
// A tick beat is taken on every cycle the pipeline has room, and a beat whose
// tick_source does not match run_mode is consumed and dropped with no result.
// A matching beat passes stages a to e into one result beat; unless the result
// stalls on rsp_bus.ready, a new beat can follow every cycle (one item per clock).
// The five stages are: rate error capture, gain multiplies (one 17x25
// multiplier per gain and axis), integral update, q16 rounding of p plus
// integral, and the motor mix into the result register. The integral
// accumulator is the only loop: one add and clamp per axis in stage three,
// so back-to-back beats see each other's integral with no hazard. Each stage
// holds its own valid, so bubbles close up while the result waits for
// rsp_bus.ready. Gains are q8.16, the integral is q16.16 clamped to 32 bits;
// pi outputs and motor sums stay well inside 32 bits and need no clamp.
// The user must write configuration through csr_we/csr_index/csr_wdata only
// while the block is idle (the block does not enforce it); indexes past the list are ignored.
//------------------------------------------------------------------------------
`default_nettype none

module quad_rate_pi_motor_mixer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   qrpi_req_if.sink                                req_bus,
   qrpi_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [qrpi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [qrpi_pkg::GAIN_W-1:0]        csr_wdata
);

   localparam int AXES = qrpi_pkg::AXES;

   // configuration registers
   logic [qrpi_pkg::MODE_W-1:0] run_mode_ff;
   qrpi_pkg::gain_type          kp_ff [AXES];
   qrpi_pkg::gain_type          ki_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff <= qrpi_pkg::MODE_OFF;
         kp_ff[0]    <= qrpi_pkg::KP_ROLL_RST;
         kp_ff[1]    <= qrpi_pkg::KP_PITCH_RST;
         kp_ff[2]    <= qrpi_pkg::KP_YAW_RST;
         ki_ff[0]    <= qrpi_pkg::KI_ROLL_RST;
         ki_ff[1]    <= qrpi_pkg::KI_PITCH_RST;
         ki_ff[2]    <= qrpi_pkg::KI_YAW_RST;
      end else if (csr_we) begin
         case (csr_index)
            qrpi_pkg::CSR_RUN_MODE: run_mode_ff <= csr_wdata[qrpi_pkg::MODE_W-1:0];
            qrpi_pkg::CSR_KP_ROLL:  kp_ff[0] <= csr_wdata;
            qrpi_pkg::CSR_KP_PITCH: kp_ff[1] <= csr_wdata;
            qrpi_pkg::CSR_KP_YAW:   kp_ff[2] <= csr_wdata;
            qrpi_pkg::CSR_KI_ROLL:  ki_ff[0] <= csr_wdata;
            qrpi_pkg::CSR_KI_PITCH: ki_ff[1] <= csr_wdata;
            qrpi_pkg::CSR_KI_YAW:   ki_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and the ready chain back from the result register
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

   assign e_rdy = !e_vld_ff || rsp_bus.ready;
   assign d_rdy = !d_vld_ff || e_rdy;
   assign c_rdy = !c_vld_ff || d_rdy;
   assign b_rdy = !b_vld_ff || c_rdy;
   assign a_rdy = !a_vld_ff || b_rdy;

   assign req_bus.ready = a_rdy;

   // a tick runs only when its source matches the mode; mode 3 never matches
   logic tick_runs;
   assign tick_runs =
      (run_mode_ff == qrpi_pkg::MODE_GYRO && req_bus.tick_source == qrpi_pkg::SRC_GYRO) ||
      (run_mode_ff == qrpi_pkg::MODE_MS   && req_bus.tick_source == qrpi_pkg::SRC_MS);

   logic a_vld_in;
   assign a_vld_in = req_bus.valid && tick_runs;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) a_vld_ff <= a_vld_in;
         if (b_rdy) b_vld_ff <= a_vld_ff;
         if (c_rdy) c_vld_ff <= b_vld_ff;
         if (d_rdy) d_vld_ff <= c_vld_ff;
         if (e_rdy) e_vld_ff <= d_vld_ff;
      end
   end

   // stage a: rate errors, exact in 17 bits
   qrpi_pkg::err_type            err_in [AXES];
   qrpi_pkg::err_type            err_a_ff [AXES];
   logic [qrpi_pkg::THRUST_W-1:0] thr_a_ff;

   assign err_in[0] = qrpi_pkg::ERR_W'(req_bus.tgt_roll)  - qrpi_pkg::ERR_W'(req_bus.meas_roll);
   assign err_in[1] = qrpi_pkg::ERR_W'(req_bus.tgt_pitch) - qrpi_pkg::ERR_W'(req_bus.meas_pitch);
   assign err_in[2] = qrpi_pkg::ERR_W'(req_bus.tgt_yaw)   - qrpi_pkg::ERR_W'(req_bus.meas_yaw);

   always_ff @(posedge clock) begin
      if (a_rdy && a_vld_in) begin
         err_a_ff <= err_in;
         thr_a_ff <= req_bus.thrust;
      end
   end

   // stage b: proportional and integral products
   qrpi_pkg::prod_type            pp_b_ff [AXES];
   qrpi_pkg::prod_type            ip_b_ff [AXES];
   logic [qrpi_pkg::THRUST_W-1:0] thr_b_ff;

   always_ff @(posedge clock) begin
      if (b_rdy && a_vld_ff) begin
         for (int i = 0; i < AXES; i++) begin
            pp_b_ff[i] <= qrpi_pkg::gain_mul(err_a_ff[i], kp_ff[i]);
            ip_b_ff[i] <= qrpi_pkg::gain_mul(err_a_ff[i], ki_ff[i]);
         end
         thr_b_ff <= thr_a_ff;
      end
   end

   // stage c: integral accumulate and clamp, the only recurrence
   qrpi_pkg::word_type            integ_ff [AXES];
   qrpi_pkg::word_type            integ_in [AXES];
   qrpi_pkg::prod_type            pp_c_ff [AXES];
   qrpi_pkg::word_type            acc_c_ff [AXES];
   logic [qrpi_pkg::THRUST_W-1:0] thr_c_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         integ_in[i] = qrpi_pkg::sat_acc(qrpi_pkg::ACCS_W'(integ_ff[i]) +
                                         qrpi_pkg::ACCS_W'(ip_b_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) integ_ff[i] <= '0;
      end else if (c_rdy && b_vld_ff) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_rdy && b_vld_ff) begin
         pp_c_ff  <= pp_b_ff;
         acc_c_ff <= integ_in;
         thr_c_ff <= thr_b_ff;
      end
   end

   // stage d: p plus integral, rounded half up to an integer (floor shift)
   logic signed [qrpi_pkg::PSUM_W-1:0] psum [AXES];
   qrpi_pkg::pid_type                  pid_d_ff [AXES];
   logic [qrpi_pkg::THRUST_W-1:0]      thr_d_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         psum[i] = qrpi_pkg::PSUM_W'(pp_c_ff[i]) + qrpi_pkg::PSUM_W'(acc_c_ff[i]) +
                   qrpi_pkg::ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (d_rdy && c_vld_ff) begin
         for (int i = 0; i < AXES; i++) begin
            pid_d_ff[i] <= psum[i][qrpi_pkg::PSUM_W-1:qrpi_pkg::FRAC_W];
         end
         thr_d_ff <= thr_c_ff;
      end
   end

   // stage e: x-frame mix into the result register
   typedef logic signed [qrpi_pkg::MIX_W-1:0] mix_type;

   mix_type thr_m, r_m, p_m, y_m;
   mix_type fl_in, fr_in, br_in, bl_in;
   mix_type fl_ff, fr_ff, br_ff, bl_ff;
   qrpi_pkg::pid_type pid_e_ff [AXES];

   assign thr_m = mix_type'({1'b0, thr_d_ff});
   assign r_m   = qrpi_pkg::MIX_W'(pid_d_ff[0]);
   assign p_m   = qrpi_pkg::MIX_W'(pid_d_ff[1]);
   assign y_m   = qrpi_pkg::MIX_W'(pid_d_ff[2]);

   assign fl_in = thr_m + r_m - p_m - y_m;
   assign fr_in = thr_m - r_m - p_m + y_m;
   assign br_in = thr_m - r_m + p_m - y_m;
   assign bl_in = thr_m + r_m + p_m + y_m;

   always_ff @(posedge clock) begin
      if (e_rdy && d_vld_ff) begin
         fl_ff    <= fl_in;
         fr_ff    <= fr_in;
         br_ff    <= br_in;
         bl_ff    <= bl_in;
         pid_e_ff <= pid_d_ff;
      end
   end

   assign rsp_bus.valid             = e_vld_ff;
   assign rsp_bus.motor_front_left  = qrpi_pkg::OUT_W'(fl_ff);
   assign rsp_bus.motor_front_right = qrpi_pkg::OUT_W'(fr_ff);
   assign rsp_bus.motor_back_right  = qrpi_pkg::OUT_W'(br_ff);
   assign rsp_bus.motor_back_left   = qrpi_pkg::OUT_W'(bl_ff);
   assign rsp_bus.pid_roll          = qrpi_pkg::OUT_W'(pid_e_ff[0]);
   assign rsp_bus.pid_pitch         = qrpi_pkg::OUT_W'(pid_e_ff[1]);
   assign rsp_bus.pid_yaw           = qrpi_pkg::OUT_W'(pid_e_ff[2]);

endmodule

`default_nettype wire

FILE: design/qrpi_checker.sv
//------------------------------------------------------------------------------
// qrpi_checker
// port-level checks on the result channel of the rate pi mixer
//------------------------------------------------------------------------------
`default_nettype none

module qrpi_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  fl,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  fr,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  br,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  bl,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  pitch,
   input wire logic signed [qrpi_pkg::OUT_W-1:0]  yaw
);

   localparam int CW = qrpi_pkg::OUT_W + 2;

   logic signed [CW-1:0] bl_minus_fl, fr_minus_br, pitch_yaw2, yaw_pitch2;

   assign bl_minus_fl = CW'(bl) - CW'(fl);
   assign fr_minus_br = CW'(fr) - CW'(br);
   assign pitch_yaw2  = (CW'(pitch) + CW'(yaw)) <<< 1;
   assign yaw_pitch2  = (CW'(yaw) - CW'(pitch)) <<< 1;

   // a waiting result beat stays valid with fl and bl held stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(fl) && $stable(bl))
      else $error("result beat dropped or changed while stalled");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // back left minus front left is twice pitch plus yaw; front right minus back right is twice yaw minus pitch
   a_mix_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bl_minus_fl == pitch_yaw2)
      else $error("left-side motor mix inconsistent with pi outputs");

   a_mix_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fr_minus_br == yaw_pitch2)
      else $error("right-side motor mix inconsistent with pi outputs");

endmodule

bind quad_rate_pi_motor_mixer_unit qrpi_checker u_qrpi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .fl        (rsp_bus.motor_front_left),
   .fr        (rsp_bus.motor_front_right),
   .br        (rsp_bus.motor_back_right),
   .bl        (rsp_bus.motor_back_left),
   .pitch     (rsp_bus.pid_pitch),
   .yaw       (rsp_bus.pid_yaw)
);

`default_nettype wire
